### sv/bmp_pkg.sv
// Shared types and constants for the block mosaic pixelator.
// No dependencies; every other file of the block except bmp_ram uses this package.
package bmp_pkg;

    localparam int COLOR_BITS   = 8;
    localparam int PIXEL_BITS   = 3 * COLOR_BITS;
    localparam int IMG_W_BITS   = 11;
    localparam int IMG_H_BITS   = 13;
    localparam int BLK_BITS     = 7;
    localparam int ROW_BITS     = 12;
    localparam int BLK_POS_BITS = 6;

    localparam int MAX_FRAME_HEIGHT = 4096;
    localparam int MAX_BLOCK        = 64;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd700;
    localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 13'd700;
    localparam logic [BLK_BITS-1:0]   RST_BLOCK_SIZE   = 7'd10;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BLOCK_SIZE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [IMG_W_BITS-1:0] image_width;
        logic [IMG_H_BITS-1:0] image_height;
        logic [BLK_BITS-1:0]   block_size;
    } cfg_t;

    // Per-pixel position flags from the scan counters
    typedef struct packed {
        logic first_row;   // first line of a block row: color comes from the sample
        logic sample;      // top-left pixel of a block: sample and write the store
        logic frame_last;  // last column of the last line
    } scan_t;

endpackage

### sv/bmp_pix_in_if.sv
// Input pixel channel: valid/ready handshake with one BGR pixel and frame mark.
// Depends on bmp_pkg.
interface bmp_pix_in_if;
    logic                            valid;
    logic                            ready;
    logic [bmp_pkg::COLOR_BITS-1:0]  blue_in;
    logic [bmp_pkg::COLOR_BITS-1:0]  green_in;
    logic [bmp_pkg::COLOR_BITS-1:0]  red_in;
    logic                            frame_start;

    modport source (output valid, blue_in, green_in, red_in, frame_start, input ready);
    modport sink   (input valid, blue_in, green_in, red_in, frame_start, output ready);
endinterface

### sv/bmp_pix_out_if.sv
// Output pixel channel: valid/ready handshake with the block color and last mark.
// Depends on bmp_pkg.
interface bmp_pix_out_if;
    logic                            valid;
    logic                            ready;
    logic [bmp_pkg::COLOR_BITS-1:0]  blue_out;
    logic [bmp_pkg::COLOR_BITS-1:0]  green_out;
    logic [bmp_pkg::COLOR_BITS-1:0]  red_out;
    logic                            frame_last;

    modport source (output valid, blue_out, green_out, red_out, frame_last, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, frame_last, output ready);
endinterface

### sv/bmp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/bmp_cfg.sv
// APB register file: image width, image height and block size.
// Depends on bmp_pkg.
module bmp_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bmp_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [bmp_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bmp_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output bmp_pkg::cfg_t                       cfg
);

    bmp_pkg::cfg_t     cfg_reg;
    bmp_pkg::cfg_t     cfg_next;
    bmp_pkg::reg_idx_t reg_idx;
    logic              wr_xfer;

    assign pready  = 1'b1;
    assign reg_idx = bmp_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_xfer = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_idx)
            bmp_pkg::REG_IMAGE_WIDTH:
            begin
                prdata = bmp_pkg::APB_DATA_BITS'(cfg_reg.image_width);
                if (wr_xfer)
                begin
                    cfg_next.image_width = pwdata[bmp_pkg::IMG_W_BITS-1:0];
                end
            end
            bmp_pkg::REG_IMAGE_HEIGHT:
            begin
                prdata = bmp_pkg::APB_DATA_BITS'(cfg_reg.image_height);
                if (wr_xfer)
                begin
                    cfg_next.image_height = pwdata[bmp_pkg::IMG_H_BITS-1:0];
                end
            end
            bmp_pkg::REG_BLOCK_SIZE:
            begin
                prdata = bmp_pkg::APB_DATA_BITS'(cfg_reg.block_size);
                if (wr_xfer)
                begin
                    cfg_next.block_size = pwdata[bmp_pkg::BLK_BITS-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= bmp_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height <= bmp_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.block_size   <= bmp_pkg::RST_BLOCK_SIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/bmp_scan.sv
// Raster scan counters: pixel, line, in-block position and block column.
// Depends on bmp_pkg; advanced once per accepted input transfer.
module bmp_scan #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              frame_start,
    input  bmp_pkg::cfg_t                     cfg,
    output logic [$clog2(MAX_LINE_WIDTH)-1:0] slot,
    output bmp_pkg::scan_t                    scan
);

    localparam int COL_W = $clog2(MAX_LINE_WIDTH);

    logic [COL_W-1:0]                 col_reg, col_next, col_cur;
    logic [COL_W-1:0]                 bcol_reg, bcol_next, bcol_cur;
    logic [bmp_pkg::ROW_BITS-1:0]     row_reg, row_next, row_cur;
    logic [bmp_pkg::BLK_POS_BITS-1:0] cib_reg, cib_next, cib_cur;
    logic [bmp_pkg::BLK_POS_BITS-1:0] rib_reg, rib_next, rib_cur;

    logic [COL_W-1:0]                 width_m1;
    logic [bmp_pkg::ROW_BITS-1:0]     height_m1;
    logic [bmp_pkg::BLK_POS_BITS-1:0] block_m1;
    logic                             last_col;
    logic                             last_row;

    // Limits minus one, with out-of-range settings clamped
    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            width_m1 = '0;
        end
        else if (32'(cfg.image_width) > MAX_LINE_WIDTH)
        begin
            width_m1 = COL_W'(MAX_LINE_WIDTH - 1);
        end
        else
        begin
            width_m1 = COL_W'(cfg.image_width - 11'd1);
        end

        if (cfg.image_height == '0)
        begin
            height_m1 = '0;
        end
        else if (32'(cfg.image_height) > bmp_pkg::MAX_FRAME_HEIGHT)
        begin
            height_m1 = bmp_pkg::ROW_BITS'(bmp_pkg::MAX_FRAME_HEIGHT - 1);
        end
        else
        begin
            height_m1 = bmp_pkg::ROW_BITS'(cfg.image_height - 13'd1);
        end

        if (cfg.block_size == '0)
        begin
            block_m1 = '0;
        end
        else if (32'(cfg.block_size) > bmp_pkg::MAX_BLOCK)
        begin
            block_m1 = bmp_pkg::BLK_POS_BITS'(bmp_pkg::MAX_BLOCK - 1);
        end
        else
        begin
            block_m1 = bmp_pkg::BLK_POS_BITS'(cfg.block_size - 7'd1);
        end
    end

    // frame_start restarts the scan on this very pixel
    assign col_cur  = frame_start ? '0 : col_reg;
    assign bcol_cur = frame_start ? '0 : bcol_reg;
    assign row_cur  = frame_start ? '0 : row_reg;
    assign cib_cur  = frame_start ? '0 : cib_reg;
    assign rib_cur  = frame_start ? '0 : rib_reg;

    assign last_col = col_cur >= width_m1;
    assign last_row = row_cur >= height_m1;

    assign slot            = bcol_cur;
    assign scan.first_row  = (rib_cur == '0);
    assign scan.sample     = (rib_cur == '0) && (cib_cur == '0);
    assign scan.frame_last = last_col && last_row;

    always_comb
    begin
        col_next  = col_cur;
        bcol_next = bcol_cur;
        row_next  = row_cur;
        cib_next  = cib_cur;
        rib_next  = rib_cur;
        if (last_col)
        begin
            col_next  = '0;
            cib_next  = '0;
            bcol_next = '0;
            if (last_row)
            begin
                row_next = '0;
                rib_next = '0;
            end
            else
            begin
                row_next = row_cur + 1'b1;
                rib_next = (rib_cur >= block_m1) ? '0 : rib_cur + 1'b1;
            end
        end
        else
        begin
            col_next = col_cur + 1'b1;
            if (cib_cur >= block_m1)
            begin
                cib_next  = '0;
                bcol_next = bcol_cur + 1'b1;
            end
            else
            begin
                cib_next = cib_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            bcol_reg <= '0;
            row_reg  <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
        end
        else if (advance)
        begin
            col_reg  <= col_next;
            bcol_reg <= bcol_next;
            row_reg  <= row_next;
            cib_reg  <= cib_next;
            rib_reg  <= rib_next;
        end
    end

endmodule

### sv/block_mosaic_pixelate.sv
// Block mosaic pixelator. Takes BGR pixels in raster order and returns, through stage 1 and
// the output register, the color of the top-left pixel of the pixel's square block; it sustains
// one pixel per clock while the output side keeps ready high, and the input stalls only when
// both pipeline stages hold a pixel that the output has not taken. Per-block colors of the
// current block row sit in one line store of MAX_LINE_WIDTH x 24 bits: the first line of a block
// row writes each block's sample, later lines read it back, so each pixel costs at most one store
// access. The store needs no clearing after reset. image_width, image_height and block_size are
// set over APB at 0x0, 0x4, 0x8, by the user only while the block is idle; the block does not enforce it.
// Depends on bmp_pkg, bmp_pix_in_if, bmp_pix_out_if, bmp_ram, bmp_cfg and bmp_scan.
module block_mosaic_pixelate #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bmp_pix_in_if.sink                          pix_in,
    bmp_pix_out_if.source                       pix_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bmp_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [bmp_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bmp_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    localparam int PB    = bmp_pkg::PIXEL_BITS;
    localparam int CB    = bmp_pkg::COLOR_BITS;

    bmp_pkg::cfg_t  cfg;
    bmp_pkg::scan_t scan;
    logic [COL_W-1:0] slot;

    logic          in_xfer;
    logic          s1_adv;
    logic [PB-1:0] pixel;
    logic [PB-1:0] ram_rd_data;
    logic          ram_we;
    logic          ram_re;

    logic          held_valid_reg;
    logic [PB-1:0] held_reg;

    logic          s1_valid_reg, s1_valid_next;
    logic          s1_use_ram_reg;
    logic [PB-1:0] s1_color_reg;
    logic          s1_last_reg;
    logic [PB-1:0] s1_color;

    logic          out_valid_reg, out_valid_next;
    logic [PB-1:0] out_color_reg;
    logic          out_last_reg;

    bmp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmp_scan #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_xfer),
        .frame_start (pix_in.frame_start),
        .cfg         (cfg),
        .slot        (slot),
        .scan        (scan)
    );

    assign pixel = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

    // Output register frees stage 1 whenever it is empty or being drained
    assign s1_adv       = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign in_xfer      = pix_in.valid && pix_in.ready;

    // Writes happen only on the first line of a block row, reads only on the others
    assign ram_we = in_xfer && scan.sample;
    assign ram_re = in_xfer && !scan.first_row;

    bmp_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (slot),
        .wr_data (pixel),
        .rd_en   (ram_re),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (ram_we)
        begin
            held_reg       <= pixel;
            held_valid_reg <= 1'b1;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_use_ram_reg <= !scan.first_row;
            s1_color_reg   <= scan.sample ? pixel : held_reg;
            s1_last_reg    <= scan.frame_last;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_color_reg <= s1_color;
            out_last_reg  <= s1_last_reg;
        end
    end

    // Read data stays put while stage 1 stalls: no new read is issued until it moves
    assign s1_color = s1_use_ram_reg ? ram_rd_data : s1_color_reg;

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.blue_out   = out_color_reg[CB-1:0];
    assign pix_out.green_out  = out_color_reg[2*CB-1:CB];
    assign pix_out.red_out    = out_color_reg[PB-1:2*CB];
    assign pix_out.frame_last = out_last_reg;

`ifndef SYNTH
    a_store_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read in the same cycle");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_color)))
        else $error("stage 1 result lost or changed while stalled");

    a_sample_read_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && scan.first_row && !scan.sample) |-> held_valid_reg)
        else $error("block color used before any sample was taken");
`endif

endmodule
